### rtl/stss_pkg.sv
// Shared types, sizes and codes for the subarray target-sum search block.
// No dependencies; imported by every module of the block.
package stss_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int MAX_LENGTH   = 65535;

  localparam int PTR_W    = $clog2(WINDOW_DEPTH);
  localparam int STORED_W = $clog2(WINDOW_DEPTH + 1);
  localparam int VAL_W    = 31;
  localparam int IDX_W    = 16;
  localparam int TGT_W    = 63;
  // window sum never exceeds MAX_LENGTH * (2^31 - 1) < 2^47
  localparam int SUM_W    = 47;
  localparam int STAT_W   = 2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic              load;     // capture input beat
    logic              add;      // count element, add to sum
    logic              rd;       // read window head
    logic              sub;      // drop window head
    logic              wr;       // push element at tail
    logic              set_res;  // latch result, mark array done
    logic [STAT_W-1:0] res_code;
    logic              emit;     // move result to output register
    logic              clear;    // end of array
  } stss_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic match_done;
    logic len_full;
    logic drop;
    logic win_full;
    logic sum_eq;
    logic last;
  } stss_stat_t;

  function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p);
    adv_ptr = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### rtl/stss_ctrl.sv
// Sequencer for the target-sum search: one element at a time, drop loop,
// result hand-off. Depends on stss_pkg.
module stss_ctrl
  import stss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  input  stss_stat_t stat,
  output stss_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.match_done) begin
          state_next = S_FIN;
        end else if (stat.len_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OVERFLOW;
          state_next   = S_EMIT;
        end else begin
          cmd.add    = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.drop) begin
          cmd.rd     = 1'b1;
          state_next = S_SUB;
        end else if (stat.win_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OVERFLOW;
          state_next   = S_EMIT;
        end else begin
          cmd.wr = 1'b1;
          if (stat.sum_eq) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_FOUND;
            state_next   = S_EMIT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_CHECK;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // not-found also sets the done mark, so the second pass clears
        if (stat.last && !stat.match_done) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
          state_next   = S_EMIT;
        end else begin
          cmd.clear  = stat.last;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_sub_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> ($past(state) == S_CHECK && $past(stat.drop)))
    else $error("drop step without a head read");
`endif

endmodule

### rtl/stss_dp.sv
// Datapath for the target-sum search: window memory, running sum, pointers,
// counters and the result latch. Depends on stss_pkg.
module stss_dp
  import stss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [VAL_W-1:0]  value,
  input  logic              last_item,
  input  logic [TGT_W-1:0]  target_sum,
  input  stss_cmd_t         cmd,
  output stss_stat_t        stat,
  output logic [STAT_W-1:0] res_status,
  output logic [IDX_W-1:0]  res_first,
  output logic [IDX_W-1:0]  res_last
);

  logic [VAL_W-1:0]    mem [WINDOW_DEPTH];
  logic [VAL_W-1:0]    rdata;
  logic [VAL_W-1:0]    value_q;
  logic                last_q;
  logic [SUM_W-1:0]    running_sum;
  logic [IDX_W-1:0]    start_index;
  logic [IDX_W-1:0]    element_count;
  logic [PTR_W-1:0]    head_pointer;
  logic [PTR_W-1:0]    tail_pointer;
  logic [STORED_W-1:0] stored_count;
  logic                match_done;
  logic [TGT_W-1:0]    sum_ext;

  assign sum_ext = TGT_W'(running_sum);

  // window memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[tail_pointer] <= value_q;
    end
    if (cmd.rd) begin
      rdata <= mem[head_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
      last_q  <= last_item;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_first  <= (cmd.res_code == ST_FOUND) ? start_index + 1'b1 : '0;
      res_last   <= (cmd.res_code == ST_FOUND) ? element_count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_sum   <= '0;
      start_index   <= '0;
      element_count <= '0;
      head_pointer  <= '0;
      tail_pointer  <= '0;
      stored_count  <= '0;
      match_done    <= 1'b0;
    end else begin
      if (cmd.add) begin
        element_count <= element_count + 1'b1;
        running_sum   <= running_sum + SUM_W'(value_q);
      end
      if (cmd.sub) begin
        running_sum  <= running_sum - SUM_W'(rdata);
        head_pointer <= adv_ptr(head_pointer);
        stored_count <= stored_count - 1'b1;
        start_index  <= start_index + 1'b1;
      end
      if (cmd.wr) begin
        tail_pointer <= adv_ptr(tail_pointer);
        stored_count <= stored_count + 1'b1;
      end
      if (cmd.set_res) begin
        match_done <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.match_done = match_done;
    stat.len_full   = (element_count >= IDX_W'(MAX_LENGTH));
    // the new element is counted in the sum but not yet stored
    stat.drop       = (sum_ext > target_sum) && (stored_count != '0);
    stat.win_full   = (stored_count >= STORED_W'(WINDOW_DEPTH));
    stat.sum_eq     = (sum_ext == target_sum);
    stat.last       = last_q;
  end

`ifndef SYNTH
  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= STORED_W'(WINDOW_DEPTH))
    else $error("window store holds more than its depth");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= IDX_W'(MAX_LENGTH))
    else $error("element count beyond max length");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (stored_count == '0) |-> (head_pointer == tail_pointer))
    else $error("empty window with head and tail apart");
`endif

endmodule

### rtl/subarray_target_sum_search_core.sv
// Subarray target-sum search: sliding window over a stream of elements, one beat at a time.
// Each element is accepted, added to the sum, then checked; each front drop reads the window
// head from the single-read memory, then subtracts it. Found, overflow and not-found results
// are latched, then moved into the m_tdata register once the output register is free.
// A new element is accepted only after the search of the previous one has finished.
// Reset (rst, sync, active high) clears control, counters and target; memory not cleared.
module subarray_target_sum_search_core
  import stss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // element beats
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero pad
  input  logic                  s_tlast,   // last_item
  // result beats
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [17:2] first_index,
                                           // [33:18] last_index, [39:34] zero pad
  // target register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TGT_W-1:0]      cfg_data   // target_sum
);

  stss_cmd_t         cmd;
  stss_stat_t        stat;
  logic [TGT_W-1:0]  target_sum;
  logic              out_free;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_first;
  logic [IDX_W-1:0]  res_last;

  // the user writes target only while the search is idle; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_valid) begin
      target_sum <= cfg_data;
    end
  end

  // output register: free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {(OUT_DATA_W - STAT_W - 2*IDX_W)'(0), res_last, res_first, res_status};
    end
  end

  stss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  stss_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (s_tdata[VAL_W-1:0]),
    .last_item  (s_tlast),
    .target_sum (target_sum),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (res_status),
    .res_first  (res_first),
    .res_last   (res_last)
  );

endmodule
